// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, skipped while reset is high.
`define BBS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BBS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BBS_ASSERT(label, clk, rst, prop, msg)

`define BBS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/bbs_pkg.sv =====
`timescale 1ns / 1ps

package bbs_pkg;

  localparam int COORD_W = 10;
  localparam int WIN_W   = 11;
  localparam int SIZE_W  = 12;
  localparam int INDEX_W = 14;
  localparam int DATA_W  = 32;
  localparam int FRAME_W = 2;

  localparam logic [DATA_W-1:0] COLOR_MASK = 32'h00FF_FFFF;

  localparam logic [WIN_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [WIN_W-1:0] HEIGHT_RESET = 11'd480;

  // Register select bit of the config port (paddr[2]).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TEXEL = 2'd0,
    FUNC_DEPTH = 2'd1,
    FUNC_SHADE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Per-transaction context that rides along the pipeline.
  typedef struct packed {
    func_t               func;
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [INDEX_W-1:0]  load_index;
    logic [DATA_W-1:0]   load_data;
  } bbs_tag_t;

endpackage

// ===== rtl/bbs_front.sv =====
`timescale 1ns / 1ps

module bbs_front import bbs_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int FRAME_COUNT = 4,
  parameter int TEX_WIDTH   = 64,
  parameter int TEX_HEIGHT  = 64,
  parameter int NW          = 19
) (
  input  logic                      clk,
  input  logic                      take,
  input  logic [1:0]                en_stage,
  input  logic [1:0]                func,
  input  logic [INDEX_W-1:0]        load_index,
  input  logic [DATA_W-1:0]         load_data,
  input  logic [FRAME_W-1:0]        frame,
  input  logic [COORD_W-1:0]        column,
  input  logic [COORD_W-1:0]        row,
  input  logic signed [SIZE_W-1:0]  center_x,
  input  logic [SIZE_W-1:0]         sprite_size,
  input  logic [DATA_W-1:0]         sprite_depth,
  input  logic [WIN_W-1:0]          window_width,
  input  logic [WIN_W-1:0]          window_height,
  output bbs_tag_t                  tag,
  output logic [SIZE_W-1:0]         size,
  output logic [NW-1:0]             num_x,
  output logic [NW-1:0]             num_y
);

  localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [31:0] COLS   = 32'(MAX_COLUMNS);
  localparam logic [31:0] FRAMES = 32'(FRAME_COUNT);
  localparam logic [NW-1:0] TW   = NW'(TEX_WIDTH);
  localparam logic [NW-1:0] TH   = NW'(TEX_HEIGHT);

  logic [DATA_W-1:0] depth_mem [MAX_COLUMNS];

  // stage 0: captured fields and depth store read
  func_t                     f0;
  logic [FRAME_W-1:0]        fr0;
  logic [COORD_W-1:0]        col0, row0;
  logic signed [SIZE_W-1:0]  cx0;
  logic [SIZE_W-1:0]         size0;
  logic [DATA_W-1:0]         dep0, drd0, ld0;
  logic [INDEX_W-1:0]        li0;

  logic [CAW-1:0] daddr;
  logic           dwe;

  always_comb begin
    dwe   = (func_t'(func) == FUNC_DEPTH) && ({18'b0, load_index} < COLS);
    daddr = (func_t'(func) == FUNC_DEPTH) ? CAW'(load_index) : CAW'(column);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (dwe) begin
        depth_mem[daddr] <= load_data;
      end
      drd0  <= depth_mem[daddr];
      f0    <= func_t'(func);
      fr0   <= frame;
      col0  <= column;
      row0  <= row;
      cx0   <= center_x;
      size0 <= sprite_size;
      dep0  <= sprite_depth;
      li0   <= load_index;
      ld0   <= load_data;
    end
  end

  // stage 1: sprite bounds, window clip and depth test
  logic [SIZE_W-2:0]  half;
  logic signed [13:0] cx14, half14, mid14, col14, row14;
  logic signed [13:0] left, right, top, bottom, dx, dy;
  logic               in_x, in_y, hit1;
  bbs_tag_t           tag1_n, tag1;
  logic [SIZE_W-1:0]  size1, dx1, dy1;

  always_comb begin
    half   = size0[SIZE_W-1:1];
    cx14   = {{2{cx0[SIZE_W-1]}}, cx0};
    half14 = {3'b0, half};
    mid14  = {4'b0, window_height[WIN_W-1:1]};
    col14  = {4'b0, col0};
    row14  = {4'b0, row0};
    left   = cx14 - half14;
    right  = cx14 + half14;
    top    = mid14 - half14;
    bottom = mid14 + half14;
    dx     = col14 - left;
    dy     = row14 - top;
    in_x   = (col14 >= left) && (col14 < right) && ({1'b0, col0} < window_width)
             && ({22'b0, col0} < COLS);
    in_y   = (row14 >= top) && (row14 < bottom) && ({1'b0, row0} < window_height);
    hit1   = (f0 == FUNC_SHADE) && (size0 != '0) && ({30'b0, fr0} < FRAMES)
             && in_x && in_y && (dep0 < drd0);

    tag1_n.func       = f0;
    tag1_n.hit        = hit1;
    tag1_n.frame      = fr0;
    tag1_n.col        = col0;
    tag1_n.row        = row0;
    tag1_n.load_index = li0;
    tag1_n.load_data  = ld0;
  end

  always_ff @(posedge clk) begin
    if (en_stage[0]) begin
      tag1  <= tag1_n;
      size1 <= size0;
      // offsets are below size when inside; zero them otherwise
      dx1   <= hit1 ? dx[SIZE_W-1:0] : '0;
      dy1   <= hit1 ? dy[SIZE_W-1:0] : '0;
    end
  end

  // stage 2: scale offsets to texture space
  always_ff @(posedge clk) begin
    if (en_stage[1]) begin
      tag   <= tag1;
      size  <= size1;
      num_x <= NW'(dx1) * TW;
      num_y <= NW'(dy1) * TH;
    end
  end

endmodule

// ===== rtl/bbs_div_stage.sv =====
`timescale 1ns / 1ps

module bbs_div_stage import bbs_pkg::*; #(
  parameter int NW  = 19,
  parameter int QW  = 6,
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  bbs_tag_t          tag_in,
  input  logic [SIZE_W-1:0] size_in,
  input  logic [NW-1:0]     rx_in,
  input  logic [NW-1:0]     ry_in,
  input  logic [QW-1:0]     qx_in,
  input  logic [QW-1:0]     qy_in,
  output bbs_tag_t          tag_out,
  output logic [SIZE_W-1:0] size_out,
  output logic [NW-1:0]     rx_out,
  output logic [NW-1:0]     ry_out,
  output logic [QW-1:0]     qx_out,
  output logic [QW-1:0]     qy_out
);

  logic [NW:0]   dvs;
  logic          fit_x, fit_y;
  logic [NW-1:0] rx_next, ry_next;
  logic [QW-1:0] qx_next, qy_next;

  // one restoring step per lane: try subtracting size << BIT
  always_comb begin
    dvs     = (NW + 1)'(size_in) << BIT;
    fit_x   = {1'b0, rx_in} >= dvs;
    fit_y   = {1'b0, ry_in} >= dvs;
    rx_next = fit_x ? rx_in - dvs[NW-1:0] : rx_in;
    ry_next = fit_y ? ry_in - dvs[NW-1:0] : ry_in;
    qx_next = qx_in;
    qy_next = qy_in;
    qx_next[BIT] = fit_x;
    qy_next[BIT] = fit_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_out  <= tag_in;
      size_out <= size_in;
      rx_out   <= rx_next;
      ry_out   <= ry_next;
      qx_out   <= qx_next;
      qy_out   <= qy_next;
    end
  end

endmodule

// ===== rtl/bbs_back.sv =====
`timescale 1ns / 1ps

module bbs_back import bbs_pkg::*; #(
  parameter int TEX_WIDTH   = 64,
  parameter int TEX_HEIGHT  = 64,
  parameter int FRAME_COUNT = 4,
  parameter int QW          = 6
) (
  input  logic               clk,
  input  logic               take,
  input  logic               en_out,
  input  bbs_tag_t           tag_in,
  input  logic [QW-1:0]      qx,
  input  logic [QW-1:0]      qy,
  output logic               draw,
  output logic [COORD_W-1:0] pixel_x,
  output logic [COORD_W-1:0] pixel_y,
  output logic [DATA_W-1:0]  color
);

  localparam int TEXEL_COUNT = TEX_WIDTH * TEX_HEIGHT * FRAME_COUNT;
  localparam int TAW         = $clog2(TEXEL_COUNT);
  localparam logic [31:0] TEXELS = 32'(TEXEL_COUNT);
  localparam logic [31:0] TW32   = 32'(TEX_WIDTH);
  localparam logic [31:0] TH32   = 32'(TEX_HEIGHT);
  localparam logic [31:0] PLANE  = 32'(TEX_WIDTH * TEX_HEIGHT);

  logic [DATA_W-1:0] tex_mem [TEXEL_COUNT];

  logic               is_load, twe, hit_n;
  logic [31:0]        idx;
  logic [TAW-1:0]     taddr;

  logic               shade_r, hit_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [DATA_W-1:0]  trd;
  logic               draw_n;

  always_comb begin
    is_load = (tag_in.func == FUNC_TEXEL);
    idx     = 32'(tag_in.frame) * PLANE + 32'(qy) * TW32 + 32'(qx);
    taddr   = is_load ? TAW'(tag_in.load_index) : TAW'(idx);
    twe     = is_load && ({18'b0, tag_in.load_index} < TEXELS);
    hit_n   = tag_in.hit && (32'(qx) < TW32) && (32'(qy) < TH32);
  end

  // texel stage: texel writes and shade reads share one port, in order
  always_ff @(posedge clk) begin
    if (take) begin
      if (twe) begin
        tex_mem[taddr] <= tag_in.load_data;
      end
      trd     <= tex_mem[taddr];
      shade_r <= (tag_in.func == FUNC_SHADE);
      hit_r   <= hit_n;
      col_r   <= tag_in.col;
      row_r   <= tag_in.row;
    end
  end

  assign draw_n = hit_r && ((trd & COLOR_MASK) != '0);

  // result register
  always_ff @(posedge clk) begin
    if (en_out) begin
      draw    <= draw_n;
      pixel_x <= shade_r ? col_r : '0;
      pixel_y <= shade_r ? row_r : '0;
      color   <= draw_n ? trd : '0;
    end
  end

endmodule

// ===== rtl/billboard_sprite_pixel_shader.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Carries
// -------   ------------------   ------------------------------------------------
// cmd       cmd_valid/cmd_stall  func, load_index, load_data, frame, column, row,
//                                center_x, sprite_size, sprite_depth
// pix       pix_valid/pix_stall  draw, pixel_x, pixel_y, color
// apb       psel/penable/pready  window_width (paddr[2]=0), window_height (=1)
//
// One transaction per cycle sustained while pix is not stalled.
// QW = clog2(max(TEX_WIDTH, TEX_HEIGHT)) is the number of divider stages
// of the restoring divider.
// Reset clears the stage valid bits and sets the window registers to 640x480; the texture and
// depth stores are not cleared and must be loaded before they are sampled.
// A stall on pix holds only the full stages nearest the output; cmd stalls
// once every stage holds a transaction and pix is stalled.

`include "assert_macros.svh"

module billboard_sprite_pixel_shader import bbs_pkg::*; #(
  parameter int TEX_WIDTH   = 64,
  parameter int TEX_HEIGHT  = 64,
  parameter int FRAME_COUNT = 4,
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // command channel
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [1:0]                func,
  input  logic [INDEX_W-1:0]        load_index,
  input  logic [DATA_W-1:0]         load_data,
  input  logic [FRAME_W-1:0]        frame,
  input  logic [COORD_W-1:0]        column,
  input  logic [COORD_W-1:0]        row,
  input  logic signed [SIZE_W-1:0]  center_x,
  input  logic [SIZE_W-1:0]         sprite_size,
  input  logic [DATA_W-1:0]         sprite_depth,
  // pixel channel
  output logic                      pix_valid,
  input  logic                      pix_stall,
  output logic                      draw,
  output logic [COORD_W-1:0]        pixel_x,
  output logic [COORD_W-1:0]        pixel_y,
  output logic [DATA_W-1:0]         color
);

  localparam int TMAX = (TEX_WIDTH > TEX_HEIGHT) ? TEX_WIDTH : TEX_HEIGHT;
  localparam int QW   = $clog2(TMAX);
  localparam int NW   = SIZE_W + $clog2(TMAX + 1);
  // three front stages, QW divider stages, texel stage, result stage
  localparam int NS   = QW + 5;
  localparam int DIV0 = 3;
  localparam int TEX  = DIV0 + QW;
  localparam int OUTS = TEX + 1;

  // ---------------------------------------------------------------------------
  // Config registers: decoded on paddr[2], written in the APB access phase.
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0] window_width, window_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  window_width  <= pwdata[WIN_W-1:0];
        REG_HEIGHT: window_height <= pwdata[WIN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'b0, window_width};
      REG_HEIGHT: prdata = {21'b0, window_height};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or when every stage
  // after it can move; stage i only holds if stages i..NS-1 are all full
  // and the output is stalled, so bubbles collapse toward the output.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v, en;
  logic          accept;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en[i] = !(pix_stall && ((v & ({NS{1'b1}} << i)) == ({NS{1'b1}} << i)));
    end
  end

  assign cmd_stall = !en[0];
  assign accept    = cmd_valid && !cmd_stall;
  assign pix_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= cmd_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Front: capture + depth store, bounds and depth test, texture scaling.
  // ---------------------------------------------------------------------------
  bbs_tag_t          tag_d  [QW+1];
  logic [SIZE_W-1:0] size_d [QW+1];
  logic [NW-1:0]     rx_d   [QW+1];
  logic [NW-1:0]     ry_d   [QW+1];
  logic [QW-1:0]     qx_d   [QW+1];
  logic [QW-1:0]     qy_d   [QW+1];

  bbs_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .FRAME_COUNT (FRAME_COUNT),
    .TEX_WIDTH   (TEX_WIDTH),
    .TEX_HEIGHT  (TEX_HEIGHT),
    .NW          (NW)
  ) u_front (
    .clk           (clk),
    .take          (accept),
    .en_stage      (en[2:1]),
    .func          (func),
    .load_index    (load_index),
    .load_data     (load_data),
    .frame         (frame),
    .column        (column),
    .row           (row),
    .center_x      (center_x),
    .sprite_size   (sprite_size),
    .sprite_depth  (sprite_depth),
    .window_width  (window_width),
    .window_height (window_height),
    .tag           (tag_d[0]),
    .size          (size_d[0]),
    .num_x         (rx_d[0]),
    .num_y         (ry_d[0])
  );

  assign qx_d[0] = '0;
  assign qy_d[0] = '0;

  // ---------------------------------------------------------------------------
  // Divider: one quotient bit per stage, MSB first, both axes side by side.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < QW; g++) begin : g_div
    bbs_div_stage #(
      .NW  (NW),
      .QW  (QW),
      .BIT (QW - 1 - g)
    ) u_div (
      .clk      (clk),
      .en       (en[DIV0+g]),
      .tag_in   (tag_d[g]),
      .size_in  (size_d[g]),
      .rx_in    (rx_d[g]),
      .ry_in    (ry_d[g]),
      .qx_in    (qx_d[g]),
      .qy_in    (qy_d[g]),
      .tag_out  (tag_d[g+1]),
      .size_out (size_d[g+1]),
      .rx_out   (rx_d[g+1]),
      .ry_out   (ry_d[g+1]),
      .qx_out   (qx_d[g+1]),
      .qy_out   (qy_d[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Back: texture store access in transaction order, then the result register.
  // ---------------------------------------------------------------------------
  bbs_back #(
    .TEX_WIDTH   (TEX_WIDTH),
    .TEX_HEIGHT  (TEX_HEIGHT),
    .FRAME_COUNT (FRAME_COUNT),
    .QW          (QW)
  ) u_back (
    .clk     (clk),
    .take    (en[TEX] && v[TEX-1]),
    .en_out  (en[OUTS]),
    .tag_in  (tag_d[QW]),
    .qx      (qx_d[QW]),
    .qy      (qy_d[QW]),
    .draw    (draw),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .color   (color)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BBS_ASSERT(a_stall_only_full, clk, rst, cmd_stall |-> (v == {NS{1'b1}} && pix_stall), "cmd stalled with room in the pipeline")
  `BBS_ASSERT(a_draw_color, clk, rst, (pix_valid && draw) |-> ((color & COLOR_MASK) != '0), "drawn pixel has a transparent color")
  `BBS_ASSERT(a_draw_in_window, clk, rst, (pix_valid && draw) |-> ({1'b0, pixel_x} < window_width && {1'b0, pixel_y} < window_height), "drawn pixel outside the window")

endmodule
